>>> hdl/flash_eeprom_emulation_store_macros.svh
// Assertion helpers for the store. Both sample on i_clk and are off during reset.
`ifndef FLASH_EEPROM_EMULATION_STORE_MACROS_SVH
`define FLASH_EEPROM_EMULATION_STORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FEES_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FEES_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/fees_pkg.sv
package fees_pkg;

    localparam int PAGE_BYTES_DEF = 1024;

    localparam logic [7:0] CRC_POLY_RST = 8'hE0;
    localparam logic [7:0] ID_FREE_MARK = 8'hFF;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_CRC_BAD   = 3'd2;
    localparam logic [2:0] ST_RESERVED  = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    typedef struct packed {
        logic        start;
        logic [7:0]  key_id;
        logic [15:0] value;
    } t_crc_req;

    // One byte through the reflected CRC-8, eight shifts.
    function automatic logic [7:0] crc_byte(input logic [7:0] b, input logic [7:0] poly);
        logic [7:0] r;
        r = b;
        for (int k = 0; k < 8; k++) begin
            if (r[0]) begin
                r = (r >> 1) ^ poly;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

endpackage

>>> hdl/fees_ram.sv
module fees_ram #(
    parameter int DW    = 32,
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/fees_crc.sv
module fees_crc (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fees_pkg::t_crc_req i_req,
    input  logic [7:0]         i_poly,
    output logic [7:0]         o_crc,
    output logic               o_done
);

    logic [1:0]  r_step;
    logic [7:0]  r_rem;
    logic [15:0] r_value;
    logic        r_done;

    // Three bytes, one per cycle: id with the inverted start, then value low and high.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= 2'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_step)
                2'd0: begin
                    if (i_req.start) begin
                        r_rem   <= fees_pkg::crc_byte(i_req.key_id ^ 8'hFF, i_poly) ^ 8'hFF;
                        r_value <= i_req.value;
                        r_step  <= 2'd1;
                    end
                end
                2'd1: begin
                    r_rem  <= fees_pkg::crc_byte(r_rem ^ r_value[7:0], i_poly);
                    r_step <= 2'd2;
                end
                2'd2: begin
                    r_rem  <= fees_pkg::crc_byte(r_rem ^ r_value[15:8], i_poly);
                    r_step <= 2'd0;
                    r_done <= 1'b1;
                end
                default: begin
                    r_step <= 2'd0;
                end
            endcase
        end
    end

    assign o_crc  = r_rem;
    assign o_done = r_done;

endmodule

>>> hdl/flash_eeprom_emulation_store.sv
// A read scans slots from newest to oldest (S_LRD, S_LCHK), checks the CRC of a match,
// then decides and gives the result (S_DECIDE, S_RESP); one record store port bounds it.
// A write adds a CRC run; a page transfer first clears all 256 seen-map entries, then
// reads, looks up and decides each old-page slot (S_TRD, S_TSEEN, S_TDEC). Throughput: one
// word at a time; the next is accepted in the cycle after the result register is loaded.
// Reset (synchronous, active low) selects page 0 with no used slots; memory is not cleared.
module flash_eeprom_emulation_store #(
    parameter int PAGE_BYTES = fees_pkg::PAGE_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // key_id [7:0], write_value [23:8]
    input  logic        s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // read_value
    output logic [2:0]  m_axis_tuser,   // status
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data
);

    localparam int PW     = PAGE_BYTES / 4;
    localparam int SLOT_W = $clog2(PW + 1);
    localparam int DEPTH  = 2 * PW;
    localparam int ADDR_W = $clog2(DEPTH);

    typedef enum logic [3:0] {
        S_IDLE, S_LRD, S_LCHK, S_LCRC, S_DECIDE, S_ACRC,
        S_TCLR, S_TRD, S_TSEEN, S_TDEC, S_RESP
    } t_state;

    t_state              r_state;
    logic                r_kind;
    logic [7:0]          r_id;
    logic [15:0]         r_data;
    logic [15:0]         r_value;
    logic [7:0]          r_crc_stored;
    logic [2:0]          r_st;
    logic [SLOT_W-1:0]   r_idx;
    logic [SLOT_W-1:0]   r_to;
    logic [SLOT_W-1:0]   r_used;
    logic [7:0]          r_clr;
    logic [31:0]         r_word;
    logic                r_page;
    logic [7:0]          r_poly;
    logic                r_out_valid;
    logic [2:0]          r_out_status;
    logic [15:0]         r_out_value;
    logic [2:0]          r_res_status;
    logic [15:0]         r_res_value;
    fees_pkg::t_crc_req  r_crc_req;

    logic [ADDR_W-1:0]   act_base;
    logic [ADDR_W-1:0]   oth_base;
    logic [ADDR_W-1:0]   st_raddr;
    logic [ADDR_W-1:0]   st_waddr;
    logic [31:0]         st_wdata;
    logic                st_we;
    logic [31:0]         st_rdata;
    logic [7:0]          sn_raddr;
    logic [7:0]          sn_waddr;
    logic                sn_wdata;
    logic                sn_we;
    logic                sn_rdata;
    logic [7:0]          crc_val;
    logic                crc_done;
    logic                s_acc;
    logic                t_new;
    logic                t_copy;
    logic [SLOT_W-1:0]   n_to;

    assign act_base = r_page ? ADDR_W'(PW) : '0;
    assign oth_base = r_page ? '0 : ADDR_W'(PW);
    assign st_raddr = act_base + ADDR_W'(r_idx);

    assign t_new  = (r_word[15:8] != fees_pkg::ID_FREE_MARK) && !sn_rdata;
    assign t_copy = t_new && (r_to < SLOT_W'(PW));
    assign n_to   = t_copy ? r_to + SLOT_W'(1) : r_to;

    always_comb begin
        st_we    = 1'b0;
        st_waddr = oth_base + ADDR_W'(r_to);
        st_wdata = r_word;
        if (r_state == S_TDEC) begin
            st_we = t_copy;
        end else if (r_state == S_ACRC) begin
            st_we    = crc_done;
            st_waddr = act_base + ADDR_W'(r_used);
            st_wdata = {r_data, r_id, crc_val};
        end
    end

    always_comb begin
        sn_raddr = st_rdata[15:8];
        sn_we    = 1'b0;
        sn_waddr = r_clr;
        sn_wdata = 1'b0;
        if (r_state == S_TCLR) begin
            sn_we = 1'b1;
        end else if (r_state == S_TDEC) begin
            sn_we    = t_new;
            sn_waddr = r_word[15:8];
            sn_wdata = 1'b1;
        end
    end

    fees_ram #(.DW(32), .DEPTH(DEPTH), .AW(ADDR_W)) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    fees_ram #(.DW(1), .DEPTH(256), .AW(8)) u_seen (
        .i_clk   (i_clk),
        .i_we    (sn_we),
        .i_waddr (sn_waddr),
        .i_wdata (sn_wdata),
        .i_raddr (sn_raddr),
        .o_rdata (sn_rdata)
    );

    fees_crc u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_crc_req),
        .i_poly  (r_poly),
        .o_crc   (crc_val),
        .o_done  (crc_done)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_page          <= 1'b0;
            r_used          <= SLOT_W'(1);
            r_poly          <= fees_pkg::CRC_POLY_RST;
            r_out_valid     <= 1'b0;
            r_crc_req.start <= 1'b0;
        end else begin
            r_crc_req.start <= 1'b0;
            if (i_cfg_wr_en) begin
                r_poly <= i_cfg_wr_data;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        r_kind <= s_axis_tuser;
                        r_id   <= s_axis_tdata[7:0];
                        r_data <= s_axis_tdata[23:8];
                        r_idx  <= r_used - SLOT_W'(1);
                        if (s_axis_tdata[7:0] == fees_pkg::ID_FREE_MARK) begin
                            r_res_status <= fees_pkg::ST_RESERVED;
                            r_res_value  <= 16'h0000;
                            r_state      <= S_RESP;
                        end else if (r_used == SLOT_W'(1)) begin
                            r_st    <= fees_pkg::ST_NOT_FOUND;
                            r_state <= S_DECIDE;
                        end else begin
                            r_state <= S_LRD;
                        end
                    end
                end
                S_LRD: begin
                    r_state <= S_LCHK;
                end
                S_LCHK: begin
                    if (st_rdata[15:8] == r_id) begin
                        r_value          <= st_rdata[31:16];
                        r_crc_stored     <= st_rdata[7:0];
                        r_crc_req.start  <= 1'b1;
                        r_crc_req.key_id <= r_id;
                        r_crc_req.value  <= st_rdata[31:16];
                        r_state          <= S_LCRC;
                    end else if (r_idx == SLOT_W'(1)) begin
                        r_st    <= fees_pkg::ST_NOT_FOUND;
                        r_state <= S_DECIDE;
                    end else begin
                        r_idx   <= r_idx - SLOT_W'(1);
                        r_state <= S_LRD;
                    end
                end
                S_LCRC: begin
                    if (crc_done) begin
                        r_st    <= (crc_val == r_crc_stored) ? fees_pkg::ST_OK
                                                             : fees_pkg::ST_CRC_BAD;
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_res_value <= 16'h0000;
                    if (!r_kind) begin
                        r_res_status <= r_st;
                        if (r_st != fees_pkg::ST_NOT_FOUND) begin
                            r_res_value <= r_value;
                        end
                        r_state <= S_RESP;
                    end else if (r_st == fees_pkg::ST_OK && r_value == r_data) begin
                        r_res_status <= fees_pkg::ST_OK;
                        r_state      <= S_RESP;
                    end else if (r_used == SLOT_W'(PW)) begin
                        r_clr   <= 8'd0;
                        r_state <= S_TCLR;
                    end else begin
                        r_crc_req.start  <= 1'b1;
                        r_crc_req.key_id <= r_id;
                        r_crc_req.value  <= r_data;
                        r_state          <= S_ACRC;
                    end
                end
                S_ACRC: begin
                    if (crc_done) begin
                        r_used       <= r_used + SLOT_W'(1);
                        r_res_status <= fees_pkg::ST_OK;
                        r_state      <= S_RESP;
                    end
                end
                S_TCLR: begin
                    r_clr <= r_clr + 8'd1;
                    if (r_clr == 8'hFF) begin
                        r_idx   <= SLOT_W'(PW - 1);
                        r_to    <= SLOT_W'(1);
                        r_state <= S_TRD;
                    end
                end
                S_TRD: begin
                    r_state <= S_TSEEN;
                end
                S_TSEEN: begin
                    r_word  <= st_rdata;
                    r_state <= S_TDEC;
                end
                S_TDEC: begin
                    r_to <= n_to;
                    if (r_idx == SLOT_W'(1)) begin
                        // Old page is now dead; it becomes the target of the next transfer.
                        r_page <= ~r_page;
                        r_used <= n_to;
                        if (n_to == SLOT_W'(PW)) begin
                            r_res_status <= fees_pkg::ST_FULL;
                            r_state      <= S_RESP;
                        end else begin
                            r_crc_req.start  <= 1'b1;
                            r_crc_req.key_id <= r_id;
                            r_crc_req.value  <= r_data;
                            r_state          <= S_ACRC;
                        end
                    end else begin
                        r_idx   <= r_idx - SLOT_W'(1);
                        r_state <= S_TRD;
                    end
                end
                S_RESP: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out_value  <= r_res_value;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_value;
    assign m_axis_tuser  = r_out_status;

`include "flash_eeprom_emulation_store_macros.svh"

    `FEES_ASSERT_NEXT(a_accept_leaves_idle, s_acc, r_state != S_IDLE, "accepted word left block idle")
    `FEES_ASSERT_NEXT(a_transfer_flips_page, (r_state == S_TDEC) && (r_idx == SLOT_W'(1)), r_page != $past(r_page), "transfer end did not switch page")
    `FEES_ASSERT_SAME(a_copy_other_page, (r_state == S_TDEC) && st_we, ADDR_W'(st_waddr - oth_base) < ADDR_W'(PW), "transfer copy outside receiving page")
    `FEES_ASSERT_SAME(a_notfound_zero, m_axis_tvalid && (m_axis_tuser == fees_pkg::ST_NOT_FOUND), m_axis_tdata == 16'h0000, "not found word carries a value")

endmodule
